### sv/ptq_pkg.sv
// shared constants, codes and controller/datapath types for the periodic timer queue
`default_nettype none

package ptq_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned PER_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 3;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT   = 3'd0,
    KIND_FIRED   = 3'd1,
    KIND_CANCEL  = 3'd2,
    KIND_SUMMARY = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  typedef struct packed {
    logic  accept;
    logic  act;
    logic  scan_start;
    logic  fire;
    logic  emit;
    kind_e kind;
    logic  last;
  } ptq_cmd_t;

  typedef struct packed {
    logic            scan_done;
    logic            pick_valid;
    logic            full;
    logic            out_free;
    logic [OP_W-1:0] op;
  } ptq_status_t;

endpackage

`default_nettype wire

### sv/ptq_in_if.sv
// request channel: valid/ready plus one operation beat
`default_nettype none

interface ptq_in_if;
  import ptq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot_id;
  logic [TIME_W-1:0] start_deadline;
  logic [PER_W-1:0]  repeat_interval;
  logic [TIME_W-1:0] current_time;

  modport source (
    output valid, op, slot_id, start_deadline, repeat_interval, current_time,
    input  ready
  );

  modport sink (
    input  valid, op, slot_id, start_deadline, repeat_interval, current_time,
    output ready
  );
endinterface

`default_nettype wire

### sv/ptq_out_if.sv
// result channel: valid/ready plus one result beat
`default_nettype none

interface ptq_out_if;
  import ptq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [SLOT_W-1:0] result_slot;
  logic [TIME_W-1:0] fire_time;
  logic [TIME_W-1:0] next_deadline;
  logic              pending_any;
  logic              last_result;

  modport source (
    output valid, result_kind, result_slot, fire_time, next_deadline, pending_any,
           last_result,
    input  ready
  );

  modport sink (
    input  valid, result_kind, result_slot, fire_time, next_deadline, pending_any,
           last_result,
    output ready
  );
endinterface

`default_nettype wire

### sv/ptq_datapath.sv
// slot store, sequential scan unit, re-arm adder and output register
`default_nettype none

module ptq_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ptq_pkg::ptq_cmd_t          cmd_i,
  output ptq_pkg::ptq_status_t            status_o,
  input  wire logic [ptq_pkg::OP_W-1:0]   op_i,
  input  wire logic [ptq_pkg::SLOT_W-1:0] slot_id_i,
  input  wire logic [ptq_pkg::TIME_W-1:0] start_deadline_i,
  input  wire logic [ptq_pkg::PER_W-1:0]  repeat_interval_i,
  input  wire logic [ptq_pkg::TIME_W-1:0] current_time_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [ptq_pkg::KIND_W-1:0]      result_kind_o,
  output logic [ptq_pkg::SLOT_W-1:0]      result_slot_o,
  output logic [ptq_pkg::TIME_W-1:0]      fire_time_o,
  output logic [ptq_pkg::TIME_W-1:0]      next_deadline_o,
  output logic                            pending_any_o,
  output logic                            last_result_o
);
  import ptq_pkg::*;

  // slot store
  logic [TIME_W-1:0]    dl_mem [NUM_SLOTS];
  logic [PER_W-1:0]     per_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] armed_q, armed_d;
  logic [NUM_SLOTS-1:0] fired_q, fired_d;

  // latched request
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] sid_q;
  logic [TIME_W-1:0] sd_q;
  logic [PER_W-1:0]  ri_q;
  logic [TIME_W-1:0] now_q;

  logic [SLOT_W-1:0] grant_q, grant_d;
  logic              full_q;
  logic              all_armed;

  // scan pipeline
  logic              scanning_q, scanning_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic [TIME_W-1:0] rd_dl_q;
  logic [PER_W-1:0]  rd_per_q;
  logic              rd_arm_q;
  logic              rd_fired_q;

  logic              ear_any_q, ear_any_d;
  logic [TIME_W-1:0] ear_q, ear_d;
  logic              pick_v_q, pick_v_d;
  logic [SLOT_W-1:0] pick_idx_q, pick_idx_d;
  logic [TIME_W-1:0] pick_dl_q, pick_dl_d;
  logic [PER_W-1:0]  pick_per_q, pick_per_d;
  logic [SLOT_W-1:0] fire_slot_q;

  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_dl;

  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] ft_q;
  logic [TIME_W-1:0] nd_q;
  logic              pend_q;
  logic              last_q;
  logic [SLOT_W-1:0] emit_slot;

  assign all_armed = &armed_q;

  // lowest free slot
  always_comb begin
    grant_d = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        grant_d = SLOT_W'(i);
      end
    end
  end

  assign rearm_sum = {1'b0, now_q} + (TIME_W + 1)'(pick_per_q);
  assign rearm_dl  = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

  always_comb begin
    armed_d = armed_q;
    fired_d = fired_q;
    if (cmd_i.accept) begin
      fired_d = '0;
    end
    if (cmd_i.act) begin
      if (op_q == OP_ADD) begin
        if (!all_armed) begin
          armed_d[grant_d] = 1'b1;
        end
      end else begin
        armed_d[sid_q] = 1'b0;
      end
    end
    if (cmd_i.fire) begin
      fired_d[pick_idx_q] = 1'b1;
      if (pick_per_q == '0) begin
        armed_d[pick_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act && op_q == OP_ADD && !all_armed) begin
      dl_mem[grant_d]  <= sd_q;
      per_mem[grant_d] <= ri_q;
    end else if (cmd_i.fire && pick_per_q != '0) begin
      dl_mem[pick_idx_q] <= rearm_dl;
    end
    rd_dl_q  <= dl_mem[idx_q[SLOT_W-1:0]];
    rd_per_q <= per_mem[idx_q[SLOT_W-1:0]];
  end

  // scan index
  always_comb begin
    scanning_d = scanning_q;
    idx_d      = idx_q;
    if (cmd_i.scan_start) begin
      scanning_d = 1'b1;
      idx_d      = '0;
    end else if (scanning_q) begin
      if (idx_q == CNT_W'(NUM_SLOTS - 1)) begin
        scanning_d = 1'b0;
      end
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // running minimum of armed deadlines and, on a tick, of expired, unfired deadlines
  always_comb begin
    ear_any_d  = ear_any_q;
    ear_d      = ear_q;
    pick_v_d   = pick_v_q;
    pick_idx_d = pick_idx_q;
    pick_dl_d  = pick_dl_q;
    pick_per_d = pick_per_q;
    if (cmd_i.scan_start) begin
      ear_any_d = 1'b0;
      pick_v_d  = 1'b0;
    end else if (rd_vld_q && rd_arm_q) begin
      if (!ear_any_q || rd_dl_q < ear_q) begin
        ear_any_d = 1'b1;
        ear_d     = rd_dl_q;
      end
      if (op_q == OP_TICK && !rd_fired_q && rd_dl_q <= now_q &&
          (!pick_v_q || rd_dl_q < pick_dl_q)) begin
        pick_v_d   = 1'b1;
        pick_idx_d = rd_idx_q;
        pick_dl_d  = rd_dl_q;
        pick_per_d = rd_per_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      fired_q     <= '0;
      scanning_q  <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      ear_any_q   <= 1'b0;
      pick_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_ADD;
      full_q      <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      fired_q     <= fired_d;
      scanning_q  <= scanning_d;
      idx_q       <= idx_d;
      rd_vld_q    <= scanning_q && !cmd_i.scan_start;
      ear_any_q   <= ear_any_d;
      pick_v_q    <= pick_v_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        op_q <= op_i;
      end
      if (cmd_i.act) begin
        full_q <= all_armed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sid_q <= slot_id_i;
      sd_q  <= start_deadline_i;
      ri_q  <= repeat_interval_i;
      now_q <= current_time_i;
    end
    if (cmd_i.act) begin
      grant_q <= grant_d;
    end
    if (cmd_i.fire) begin
      fire_slot_q <= pick_idx_q;
    end
    rd_idx_q   <= idx_q[SLOT_W-1:0];
    rd_arm_q   <= armed_q[idx_q[SLOT_W-1:0]];
    rd_fired_q <= fired_q[idx_q[SLOT_W-1:0]];
    ear_q      <= ear_d;
    pick_idx_q <= pick_idx_d;
    pick_dl_q  <= pick_dl_d;
    pick_per_q <= pick_per_d;
  end

  // output register
  always_comb begin
    case (cmd_i.kind)
      KIND_GRANT:  emit_slot = grant_q;
      KIND_FIRED:  emit_slot = fire_slot_q;
      KIND_CANCEL: emit_slot = sid_q;
      default:     emit_slot = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      slot_q <= emit_slot;
      ft_q   <= (cmd_i.kind == KIND_FIRED) ? now_q : '0;
      nd_q   <= ear_any_q ? ear_q : '0;
      pend_q <= ear_any_q;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign result_slot_o   = slot_q;
  assign fire_time_o     = ft_q;
  assign next_deadline_o = nd_q;
  assign pending_any_o   = pend_q;
  assign last_result_o   = last_q;

  assign status_o.scan_done  = !scanning_q && !rd_vld_q;
  assign status_o.pick_valid = pick_v_q;
  assign status_o.full       = full_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.op         = op_q;

endmodule

`default_nettype wire

### sv/ptq_ctrl.sv
// operation sequencer: accept, slot update, scan, fire loop and result beats
`default_nettype none

module ptq_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [ptq_pkg::OP_W-1:0] in_op_i,
  output logic                          in_ready_o,
  output ptq_pkg::ptq_cmd_t             cmd_o,
  input  wire ptq_pkg::ptq_status_t     status_i
);
  import ptq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACT    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       fire_pend_q, fire_pend_d;

  always_comb begin
    state_d     = state_q;
    fire_pend_d = fire_pend_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.kind  = KIND_SUMMARY;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_op_i) inside
            OP_ADD, OP_CANCEL: state_d = S_ACT;
            OP_TICK: begin
              cmd_o.scan_start = 1'b1;
              fire_pend_d      = 1'b0;
              state_d          = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ACT: begin
        cmd_o.act        = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.op == OP_TICK) begin
          if (fire_pend_q) begin
            if (status_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = KIND_FIRED;
              fire_pend_d = 1'b0;
            end
          end else if (status_i.pick_valid) begin
            state_d = S_UPDATE;
          end else if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_SUMMARY;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (status_i.op == OP_ADD) begin
            cmd_o.kind = status_i.full ? KIND_FULL : KIND_GRANT;
          end else begin
            cmd_o.kind = KIND_CANCEL;
          end
          state_d = S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd_o.fire       = 1'b1;
        cmd_o.scan_start = 1'b1;
        fire_pend_d      = 1'b1;
        state_d          = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fire_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fire_pend_q <= fire_pend_d;
    end
  end

endmodule

`default_nettype wire

### sv/periodic_timer_queue.sv
// periodic timer queue top level: sequencer plus slot datapath
//
//  channel | dir | beat
//  --------+-----+--------------------------------------------------------------
//  in_i    | in  | op, slot_id, start_deadline, repeat_interval, current_time
//  out_o   | out | result_kind, result_slot, fire_time, next_deadline,
//          |     | pending_any, last_result
//
// add and cancel run through the accept step, an update step, a scan of the 16-entry slot
// store (one entry per cycle through its single read port) and one beat
// tick: accept and scan, then update, rescan and beat per fired timer, then a summary beat
// reset clears the armed and fired bits; deadline and period entries are written on add
// results leave through a one-beat output register; a stalled result holds the
// sequencer in its emit step, and a new request is taken once the last beat is
// registered
`default_nettype none

module periodic_timer_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptq_in_if.sink    in_i,
  ptq_out_if.source out_o
);
  import ptq_pkg::*;

  ptq_cmd_t    cmd;
  ptq_status_t status;

  ptq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ptq_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .op_i              (in_i.op),
    .slot_id_i         (in_i.slot_id),
    .start_deadline_i  (in_i.start_deadline),
    .repeat_interval_i (in_i.repeat_interval),
    .current_time_i    (in_i.current_time),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .result_kind_o     (out_o.result_kind),
    .result_slot_o     (out_o.result_slot),
    .fire_time_o       (out_o.fire_time),
    .next_deadline_o   (out_o.next_deadline),
    .pending_any_o     (out_o.pending_any),
    .last_result_o     (out_o.last_result)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for the periodic timer queue: directed and random request traffic
`default_nettype none

module tb_top;
  import ptq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] next_deadline;
    logic              pending;
    logic              last;
  } timer_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  ptq_in_if  req_if ();
  ptq_out_if rsp_if ();

  periodic_timer_queue u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer table as the block should hold it
  logic              timer_armed    [NUM_SLOTS];
  logic [TIME_W-1:0] timer_deadline [NUM_SLOTS];
  logic [PER_W-1:0]  timer_period   [NUM_SLOTS];
  timer_beat_t       result_beats_q [$];

  logic [TIME_W-1:0] tick_now;
  bit                idle_en;
  int                n_errors;
  int                n_items;
  int                n_beats;
  int                n_fired;
  int                n_full;

  function automatic bit earliest_deadline(output logic [TIME_W-1:0] nd);
    bit any;
    int i;
    any = 1'b0;
    nd  = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (timer_armed[i] && (!any || timer_deadline[i] < nd)) begin
        nd  = timer_deadline[i];
        any = 1'b1;
      end
    end
    return any;
  endfunction

  function automatic void push_beat(kind_e kind, logic [SLOT_W-1:0] slot,
                                    logic [TIME_W-1:0] ft, logic last);
    timer_beat_t       b;
    logic [TIME_W-1:0] nd;
    b.kind          = kind;
    b.slot          = slot;
    b.fire_time     = ft;
    b.pending       = earliest_deadline(nd);
    b.next_deadline = nd;
    b.last          = last;
    result_beats_q.push_back(b);
  endfunction

  function automatic void apply_timer_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sid,
                                         logic [TIME_W-1:0] sd, logic [PER_W-1:0] ri,
                                         logic [TIME_W-1:0] ct);
    bit [NUM_SLOTS-1:0] fired;
    bit                 granted;
    int                 pick;
    int                 i;
    logic [TIME_W:0]    sum;
    case (op)
      OP_ADD: begin
        granted = 1'b0;
        for (i = 0; i < NUM_SLOTS && !granted; i++) begin
          if (!timer_armed[i]) begin
            timer_armed[i]    = 1'b1;
            timer_deadline[i] = sd;
            timer_period[i]   = ri;
            push_beat(KIND_GRANT, SLOT_W'(i), '0, 1'b1);
            granted = 1'b1;
          end
        end
        if (!granted) push_beat(KIND_FULL, '0, '0, 1'b1);
      end
      OP_CANCEL: begin
        if (sid < NUM_SLOTS) timer_armed[sid] = 1'b0;
        push_beat(KIND_CANCEL, sid, '0, 1'b1);
      end
      OP_TICK: begin
        fired = '0;
        do begin
          pick = -1;
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (timer_armed[i] && !fired[i] && timer_deadline[i] <= ct &&
                (pick < 0 || timer_deadline[i] < timer_deadline[pick]))
              pick = i;
          end
          if (pick >= 0) begin
            fired[pick] = 1'b1;
            if (timer_period[pick] != '0) begin
              // re-arm saturates at the top of the time range
              sum = {1'b0, ct} + (TIME_W + 1)'(timer_period[pick]);
              timer_deadline[pick] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end else begin
              timer_armed[pick] = 1'b0;
            end
            push_beat(KIND_FIRED, SLOT_W'(pick), ct, 1'b0);
          end
        end while (pick >= 0);
        push_beat(KIND_SUMMARY, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  task automatic send_timer_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sid,
                               input logic [TIME_W-1:0] sd, input logic [PER_W-1:0] ri,
                               input logic [TIME_W-1:0] ct);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.op              <= op;
    req_if.slot_id         <= sid;
    req_if.start_deadline  <= sd;
    req_if.repeat_interval <= ri;
    req_if.current_time    <= ct;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_timer_op(op, sid, sd, ri, ct);
    n_items++;
  endtask

  // result side: ready with random stall bursts
  initial begin : result_ready_gen
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        hold = $urandom_range(0, 8);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [TIME_W-1:0] e, logic [TIME_W-1:0] a);
    if (a !== e) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : beat_check
    timer_beat_t exp_b;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      n_beats++;
      if (rsp_if.result_kind == KIND_FIRED) n_fired++;
      if (rsp_if.result_kind == KIND_FULL) n_full++;
      if (result_beats_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual kind %0d slot %0d", $time,
                 rsp_if.result_kind, rsp_if.result_slot);
        n_errors++;
      end else begin
        exp_b = result_beats_q.pop_front();
        check_field("result_kind", TIME_W'(exp_b.kind), TIME_W'(rsp_if.result_kind));
        check_field("result_slot", TIME_W'(exp_b.slot), TIME_W'(rsp_if.result_slot));
        check_field("fire_time", exp_b.fire_time, rsp_if.fire_time);
        check_field("next_deadline", exp_b.next_deadline, rsp_if.next_deadline);
        check_field("pending_any", TIME_W'(exp_b.pending), TIME_W'(rsp_if.pending_any));
        check_field("last_result", TIME_W'(exp_b.last), TIME_W'(rsp_if.last_result));
      end
    end
  end

  task automatic test_edges();
    send_timer_op(OP_TICK, 4'hf, '1, '1, '0);
    send_timer_op(OP_ADD, 4'h0, '0, '0, '1);
    send_timer_op(OP_ADD, 4'h5, '1, '1, '0);
    send_timer_op(OP_ADD, 4'ha, 48'd100, 32'd50, rand_time());
    // same deadline as the slot before, lower slot wins
    send_timer_op(OP_ADD, 4'h3, 48'd100, 32'd0, rand_time());
    send_timer_op(OP_UNUSED, 4'hf, rand_time(), $urandom, rand_time());
    send_timer_op(OP_TICK, 4'h0, '0, '0, 48'd100);
    // top of range: saturating re-arm, each slot fires once
    send_timer_op(OP_TICK, 4'h0, '0, '0, '1);
    send_timer_op(OP_CANCEL, 4'h1, rand_time(), $urandom, rand_time());
    send_timer_op(OP_CANCEL, 4'h1, '0, '0, '0);
  endtask

  task automatic test_table_full();
    int k;
    for (k = 0; k < NUM_SLOTS; k++)
      send_timer_op(OP_ADD, SLOT_W'($urandom), rand_time(), $urandom, rand_time());
  endtask

  task automatic test_random_mix(input int count);
    int                k;
    int                sel;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] sid;
    logic [TIME_W-1:0] sd;
    logic [PER_W-1:0]  ri;
    logic [TIME_W-1:0] ct;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      sid = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      sd  = rand_time();
      ri  = $urandom;
      ct  = rand_time();
      if (sel < 35) begin
        op = OP_ADD;
        case ($urandom_range(0, 9))
          0: ;
          1: sd = (tick_now > TIME_W'(50)) ? tick_now - TIME_W'($urandom_range(0, 50)) : '0;
          default: sd = tick_now + TIME_W'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: ri = '0;
          4: ;
          5: ri = '1;
          default: ri = $urandom_range(1, 200);
        endcase
      end else if (sel < 55) begin
        op = OP_CANCEL;
      end else if (sel < 96) begin
        op = OP_TICK;
        if ($urandom_range(0, 19) != 0) begin
          tick_now = tick_now + TIME_W'($urandom_range(0, 150));
          ct = tick_now;
        end
      end else begin
        op = OP_UNUSED;
      end
      send_timer_op(op, sid, sd, ri, ct);
    end
  endtask

  initial begin : run_limit
    #12_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : main_seq
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      timer_armed[i]    = 1'b0;
      timer_deadline[i] = '0;
      timer_period[i]   = '0;
    end
    n_errors = 0;
    n_items  = 0;
    n_beats  = 0;
    n_fired  = 0;
    n_full   = 0;
    tick_now = 48'd1000;
    idle_en  = 1'b1;
    rst_n    = 1'b0;
    req_if.valid           = 1'b0;
    req_if.op              = OP_ADD;
    req_if.slot_id         = '0;
    req_if.start_deadline  = '0;
    req_if.repeat_interval = '0;
    req_if.current_time    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges();
    test_table_full();
    test_random_mix(274);
    // no idling in the last stretch
    idle_en = 1'b0;
    test_random_mix(80);

    req_if.valid <= 1'b0;
    while (result_beats_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("ran %0d requests, %0d result beats checked", n_items, n_beats);
    $display("including %0d timer fires and %0d table-full replies", n_fired, n_full);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/ptq_pkg.sv
sv/ptq_in_if.sv
sv/ptq_out_if.sv
sv/ptq_datapath.sv
sv/ptq_ctrl.sv
sv/periodic_timer_queue.sv
dv/tb_top.sv
